@@ rtl/knn_regression_engine_defines.svh @@
// Assertion macros for the k-nearest-neighbors regression engine.
// Included by the engine, the one file that carries concurrent assertions; no other dependency.
`ifndef KNN_REGRESSION_ENGINE_DEFINES_SVH
`define KNN_REGRESSION_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define KNN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KNN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KNN_ASSERT(lbl, clk, rst_n, prop, msg)
`define KNN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/knn_pkg.sv @@
// Shared types and codes of the k-nearest-neighbors regression engine.
// No dependencies.
package knn_pkg;
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_FEW_PTS  = 2'd2;

    localparam logic [1:0] REG_LEVELS    = 2'd0;
    localparam logic [1:0] REG_COORD_TOL = 2'd1;
    localparam logic [1:0] REG_DIST_TOL  = 2'd2;
    localparam logic [1:0] REG_DIMS      = 2'd3;

    localparam int DistW = 34;
    localparam int CfgW  = 34;
    // the level anchor starts one below zero
    localparam logic [DistW:0] AnchorStartGap = (DistW+1)'(1);

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [15:0]  coord_a;
        logic signed [15:0]  coord_b;
        logic signed [15:0]  coord_c;
        logic signed [15:0]  coord_d;
        logic signed [15:0]  target_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]  answer_value;
        logic [1:0]          status;
        logic                exact_hit;
        logic [8:0]          neighbours_used;
    } t_out_item;

    typedef struct packed {
        logic                vld;
        logic [DistW-1:0]    dval;
        logic signed [15:0]  tgt;
    } t_cell;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_cell_ctl;
endpackage

@@ rtl/knn_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat.
// Depends on knn_pkg for the default payload type.
interface knn_stream_if #(parameter type T = knn_pkg::t_in_item) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/knn_regression_engine.sv @@
// k-nearest-neighbors regression engine: point store, sorted cell chain, divider.
// Depends on knn_pkg, knn_stream_if, knn_ram, knn_cell, knn_div and the defines.
// Clear and load beats go straight to S_OUT; cmd 3 likewise, with an all-zero result.
// A query scans each stored point (S_READ, S_DIM, S_ADD) and inserts it in sorted order
// (S_PUSH; one shared multiplier, one dimension per cycle), then averages the chain
// head in S_DRAIN, divides in S_DIV and posts the result in S_OUT; an exact hit skips
// insertion, drain and divider. One beat is in work at a time; a new beat is taken
// while a result waits. Synchronous active-low reset empties the store and sets the
// registers to defaults.
`include "knn_regression_engine_defines.svh"
module knn_regression_engine #(
    parameter int MAX_POINTS = 256,
    parameter int MAX_DIMS   = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    knn_stream_if.sink                i_in,
    knn_stream_if.source              o_out,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [knn_pkg::CfgW-1:0]  i_cfg_data
);
    import knn_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = AW + 1;
    localparam int SW   = 17 + AW;
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam logic [2:0] DimsMax = 3'(MAX_DIMS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_DIM   = 8'b0000_0100,
        S_ADD   = 8'b0000_1000,
        S_PUSH  = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [7:0]       r_k;
    logic [15:0]      r_ctol;
    logic [DistW-1:0] r_dtol;
    logic [2:0]       r_dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= 8'd1;
            r_ctol <= 16'd0;
            r_dtol <= '0;
            r_dims <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEVELS:    r_k    <= i_cfg_data[7:0];
                REG_COORD_TOL: r_ctol <= i_cfg_data[15:0];
                REG_DIST_TOL:  r_dtol <= i_cfg_data[DistW-1:0];
                REG_DIMS:      r_dims <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamp the dimension count to 1..MAX_DIMS
    logic [2:0] w_dims;
    always_comb begin
        if (r_dims == 3'd0) begin
            w_dims = 3'd1;
        end else if (r_dims > DimsMax) begin
            w_dims = DimsMax;
        end else begin
            w_dims = r_dims;
        end
    end

    logic w_acc;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;

    // point and target stores
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic               w_we;
    logic [63:0]        w_pt_rd;
    logic [15:0]        w_tg_rd;

    assign w_we = w_acc && (i_in.data.cmd == CMD_LOAD) && (r_count != CW'(MAX_POINTS));

    knn_ram #(.W(64), .D(MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in.data.coord_d, i_in.data.coord_c,
                   i_in.data.coord_b, i_in.data.coord_a}),
        .i_raddr (r_idx),
        .o_rdata (w_pt_rd)
    );

    knn_ram #(.W(16), .D(MAX_POINTS)) u_tg_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.data.target_value),
        .i_raddr (r_idx),
        .o_rdata (w_tg_rd)
    );

    // status known at accept time: full store on a load, few points on a query
    logic [1:0] w_st_first;
    always_comb begin
        if (i_in.data.cmd == CMD_LOAD && r_count == CW'(MAX_POINTS)) begin
            w_st_first = STATUS_FULL;
        end else if (i_in.data.cmd == CMD_QUERY && CMPW'(r_count) <= CMPW'(r_k)) begin
            w_st_first = STATUS_FEW_PTS;
        end else begin
            w_st_first = STATUS_OK;
        end
    end

    // query datapath: one dimension per cycle through one multiplier
    logic signed [15:0] r_q [4];
    logic [1:0]         r_dim;
    logic [DistW-1:0]   r_dist;
    logic [DistW-1:0]   r_sq;
    logic               r_sq_v;
    logic               r_match;
    logic signed [15:0] w_coord;
    logic signed [16:0] w_diff;
    logic [16:0]        w_ad;
    logic               w_last_dim;

    always_comb begin
        case (r_dim)
            2'd0:    w_coord = signed'(w_pt_rd[15:0]);
            2'd1:    w_coord = signed'(w_pt_rd[31:16]);
            2'd2:    w_coord = signed'(w_pt_rd[47:32]);
            default: w_coord = signed'(w_pt_rd[63:48]);
        endcase
    end

    assign w_diff     = 17'(w_coord) - 17'(r_q[r_dim]);
    assign w_ad       = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_last_dim = ({1'b0, r_dim} == (w_dims - 3'd1));

    // sorted cell chain
    t_cell     w_cell [MAX_POINTS];
    logic      w_gt   [MAX_POINTS];
    t_cell_ctl w_ctl;
    t_cell     w_new;
    t_cell     w_head;

    assign w_new  = '{vld: 1'b1, dval: r_dist, tgt: signed'(w_tg_rd)};
    assign w_head = w_cell[0];

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_chain
        t_cell w_prev;
        t_cell w_next;
        logic  w_prev_gt;
        if (g == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_gt = 1'b0;
        end else begin : g_mid
            assign w_prev    = w_cell[g-1];
            assign w_prev_gt = w_gt[g-1];
        end
        if (g == MAX_POINTS - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_cell[g+1];
        end
        knn_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_new     (w_new),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_cell    (w_cell[g]),
            .o_gt      (w_gt[g])
        );
    end

    // level walk over the chain head
    logic [8:0]         r_left;
    logic               r_anc_start;
    logic [DistW-1:0]   r_anchor;
    logic signed [SW-1:0] r_sum;
    logic [CW-1:0]      r_n;
    logic               w_opens;
    logic [8:0]         w_left_nx;

    always_comb begin
        if (r_anc_start) begin
            w_opens = ({1'b0, w_head.dval} + AnchorStartGap) > {1'b0, r_dtol};
        end else begin
            w_opens = (w_head.dval - r_anchor) > r_dtol;
        end
        w_left_nx = w_opens ? (r_left - 9'd1) : r_left;
    end

    assign w_ctl.clear  = w_acc && (i_in.data.cmd == CMD_QUERY);
    assign w_ctl.insert = (r_state == S_PUSH);
    assign w_ctl.shift  = (r_state == S_DRAIN) && w_head.vld && (w_left_nx != 9'd0);

    // divider
    logic                 r_div_go;
    logic                 w_div_done;
    logic signed [SW-1:0] w_quot;

    knn_div #(.SW(SW), .CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_sum),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // pending result and output register
    t_out_item r_res;
    t_out_item r_out;
    logic      r_out_v;
    logic      w_out_free;

    assign w_out_free  = !r_out_v || o_out.ready;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out <= r_res;
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_div_go <= 1'b0;
        end else begin
            // start the divider as the drain ends
            r_div_go <= (r_state == S_DRAIN) && (!w_head.vld || w_left_nx == 9'd0);
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_in.data.cmd == CMD_QUERY) begin
                            r_state <= (r_count == '0) ? S_DRAIN : S_READ;
                        end else begin
                            r_state <= S_OUT;
                        end
                        if (i_in.data.cmd == CMD_CLEAR) begin
                            r_count <= '0;
                        end else if (w_we) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_READ:  r_state <= S_DIM;
                S_DIM:   r_state <= w_last_dim ? S_ADD : S_DIM;
                S_ADD:   r_state <= r_match ? S_OUT : S_PUSH;
                S_PUSH: begin
                    r_state <= ({1'b0, r_idx} + CW'(1) == r_count) ? S_DRAIN : S_READ;
                end
                S_DRAIN: begin
                    if (!w_head.vld || w_left_nx == 9'd0) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV:   r_state <= w_div_done ? S_OUT : S_DIV;
                S_OUT:   r_state <= w_out_free ? S_IDLE : S_OUT;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q[0]      <= i_in.data.coord_a;
                r_q[1]      <= i_in.data.coord_b;
                r_q[2]      <= i_in.data.coord_c;
                r_q[3]      <= i_in.data.coord_d;
                r_idx       <= '0;
                r_sum       <= '0;
                r_n         <= '0;
                r_left      <= 9'(r_k) + 9'd1;
                r_anc_start <= 1'b1;
                r_res       <= '{answer_value: 16'sd0, status: w_st_first,
                                 exact_hit: 1'b0, neighbours_used: 9'd0};
            end
            S_READ: begin
                r_dim   <= '0;
                r_dist  <= '0;
                r_sq_v  <= 1'b0;
                r_match <= 1'b1;
            end
            S_DIM: begin
                r_sq    <= DistW'(w_ad * w_ad);
                r_sq_v  <= 1'b1;
                r_dist  <= r_dist + (r_sq_v ? r_sq : '0);
                r_match <= r_match && (w_ad <= {1'b0, r_ctol});
                r_dim   <= r_dim + 2'd1;
            end
            S_ADD: begin
                r_dist <= r_dist + r_sq;
                if (r_match) begin
                    r_res.answer_value    <= signed'(w_tg_rd);
                    r_res.exact_hit       <= 1'b1;
                    r_res.neighbours_used <= 9'd1;
                end
            end
            S_PUSH: begin
                r_idx <= r_idx + AW'(1);
            end
            S_DRAIN: begin
                if (w_head.vld) begin
                    r_left <= w_left_nx;
                    if (w_opens) begin
                        r_anchor    <= w_head.dval;
                        r_anc_start <= 1'b0;
                    end
                    if (w_left_nx != 9'd0) begin
                        r_sum <= r_sum + SW'(w_head.tgt);
                        r_n   <= r_n + CW'(1);
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_res.answer_value    <= (r_n == '0) ? 16'sd0 : w_quot[15:0];
                    r_res.neighbours_used <= 9'(r_n);
                end
            end
            default: ;
        endcase
    end

    `KNN_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_POINTS), "store count overflow")
    `KNN_ASSERT(a_load_inc, i_clk, i_rst_n,
                w_we |=> (r_count == $past(r_count) + CW'(1)), "load did not advance count")
    `KNN_ASSERT(a_avg_bound, i_clk, i_rst_n,
                (r_state == S_DIV) |-> (r_n <= r_count), "more points averaged than stored")
    `KNN_ASSERT(a_no_push_full, i_clk, i_rst_n,
                (r_state == S_PUSH) |-> !w_cell[MAX_POINTS-1].vld, "insert into full chain")
endmodule

@@ rtl/knn_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module knn_ram #(
    parameter int W = 16,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/knn_cell.sv @@
// One cell of the sorted distance chain: holds a distance and its target.
// Depends on knn_pkg.
module knn_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  knn_pkg::t_cell_ctl i_ctl,
    input  knn_pkg::t_cell    i_new,
    input  knn_pkg::t_cell    i_prev,
    input  logic              i_prev_gt,
    input  knn_pkg::t_cell    i_next,
    output knn_pkg::t_cell    o_cell,
    output logic              o_gt
);
    import knn_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    // an empty cell counts as larger than anything, so equal distances go behind
    assign o_gt = !r_cell.vld || (r_cell.dval > i_new.dval);

    always_comb begin
        n_cell = r_cell;
        if (i_ctl.clear) begin
            n_cell.vld = 1'b0;
        end else if (i_ctl.insert) begin
            if (o_gt) begin
                n_cell = i_prev_gt ? i_prev : i_new;
            end
        end else if (i_ctl.shift) begin
            n_cell = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= n_cell.vld;
        end
        r_cell.dval <= n_cell.dval;
        r_cell.tgt  <= n_cell.tgt;
    end

    assign o_cell = r_cell;
endmodule

@@ rtl/knn_div.sv @@
// Restoring divider: signed sum over unsigned count, quotient truncated to zero.
// No dependencies.
module knn_div #(
    parameter int SW = 25,
    parameter int CW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_dividend,
    input  logic [CW-1:0]        i_divisor,
    output logic                 o_done,
    output logic signed [SW-1:0] o_quot
);
    localparam int NW = $clog2(SW + 1);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [SW-1:0] r_quo;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_div;
    logic          r_neg;
    logic [CW:0]   w_sh;
    logic          w_fit;

    assign w_sh  = {r_rem, r_quo[SW-1]};
    assign w_fit = w_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_busy <= (r_cnt != NW'(1));
            r_done <= (r_cnt == NW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= NW'(SW);
            r_quo <= i_dividend[SW-1] ? SW'(-i_dividend) : SW'(i_dividend);
            r_neg <= i_dividend[SW-1];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - NW'(1);
            r_quo <= {r_quo[SW-2:0], w_fit};
            r_rem <= w_fit ? CW'(w_sh - {1'b0, r_div}) : CW'(w_sh);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'(r_quo) : signed'(r_quo);
endmodule
